### hw/rtl/tpbc_pkg.sv
// Shared types and constants for the tilt PD balance controller.
`timescale 1ns / 1ps

package tpbc_pkg;

    // Decimation: only every DIVIDER-th new sample is acted on.
    localparam int DECIM_W = 4;
    localparam logic [DECIM_W-1:0] DIVIDER = 4'd2;

    // Configuration port address width (six registers at 4-byte spacing).
    localparam int ADDR_W = 5;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_PROP   = 3'd1,
        REG_DERIV  = 3'd2,
        REG_TRIP   = 3'd3,
        REG_STALE  = 3'd4,
        REG_LIMIT  = 3'd5
    } reg_idx_t;

    // Live configuration handed from the register file to the datapath.
    typedef struct packed {
        logic signed [16:0] target_angle;
        logic signed [23:0] prop_gain;
        logic signed [23:0] deriv_gain;
        logic [15:0]        trip_angle;
        logic [15:0]        stale_limit_ms;
        logic [6:0]         duty_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        target_angle:   17'sd256,
        prop_gain:      24'sd691200,
        deriv_gain:     24'sd28160,
        trip_angle:     16'd10240,
        stale_limit_ms: 16'd30,
        duty_limit:     7'd96
    };

endpackage

### hw/rtl/tilt_pd_balance_controller_top.sv
// Top level of the tilt PD balance controller: decision stage and duty pipeline.
`timescale 1ns / 1ps

// The controller takes one item per clock unless the output stalls, and is
// fully pipelined: an input register, a product register holding the two
// gain multiplications, a normalize register, and the result register; a
// result passes through them in that order on its way to the master side.
// Sample filtering (stop, stale, repeated tag, decimation, tilt trip) is
// resolved in the input stage, where the controller state is updated as the
// item moves on; items that produce no result leave the pipeline there.
// Sustained rate is one item per cycle, limited only by m_axis_tready.
// Configuration registers may be written only while no item is in flight.
module tilt_pd_balance_controller_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input items.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] sample_age_ms, [47:16] sample_tag, [64:48] pitch_angle,
    // [80:65] pitch_rate, [87:81] zero
    input  logic [87:0]                 s_axis_tdata,
    // [0] action, [1] sample_valid
    input  logic [1:0]                  s_axis_tuser,
    // Result items.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] duty_cmd, [8] safe_flag, [15:9] zero
    output logic [15:0]                 m_axis_tdata,
    // [0] motor_halt
    output logic                        m_axis_tuser,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpbc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tpbc_pkg::*;

    localparam logic [48:0] ROUND_BIAS = 49'd3276800;  // half of 100 * 65536
    localparam logic [32:0] SAT_LEVEL  = 33'd12800;    // quotient 128 and up
    localparam logic [26:0] RECIP_100  = 27'd5243;     // 2^19 / 100, rounded up

    cfg_t cfg;

    // Controller state.
    logic [31:0]        prev_tag_reg;
    logic [DECIM_W-1:0] decim_count_reg;
    logic               safe_state_reg;

    // Input stage.
    logic               a_valid_reg;
    logic               a_action_reg;
    logic               a_svalid_reg;
    logic [15:0]        a_age_reg;
    logic [31:0]        a_tag_reg;
    logic signed [16:0] a_pitch_reg;
    logic signed [15:0] a_rate_reg;

    // Product stage.
    logic               b_valid_reg;
    logic               b_halt_reg;
    logic               b_safe_reg;
    logic signed [41:0] b_prop_reg;
    logic signed [39:0] b_deriv_reg;

    // Normalize stage.
    logic               c_valid_reg;
    logic               c_halt_reg;
    logic               c_safe_reg;
    logic               c_neg_reg;
    logic               c_sat_reg;
    logic [13:0]        c_quot_in_reg;

    // Result register.
    logic               m_valid_reg;
    logic               m_halt_reg;
    logic               m_safe_reg;
    logic [7:0]         m_duty_reg;

    logic               a_stop;
    logic               a_dup;
    logic [DECIM_W-1:0] a_decim_next;
    logic               a_skip;
    logic [16:0]        a_pitch_abs;
    logic               a_trip;
    logic               a_halt;
    logic               a_compute;
    logic               a_emit;
    logic               a_go;
    logic               a_safe_next;
    logic signed [23:0] kp;
    logic signed [23:0] kd;
    logic signed [17:0] a_err;
    logic signed [41:0] a_prop_prod;
    logic signed [39:0] a_deriv_prod;
    logic               b_ready;
    logic               c_ready;
    logic               o_ready;
    logic signed [48:0] b_num;
    logic [48:0]        b_mag;
    logic [48:0]        b_rounded;
    logic [32:0]        b_quot_in;
    logic [26:0]        c_recip_prod;
    logic [7:0]         c_quot;
    logic [7:0]         c_limit;
    logic [7:0]         c_mag;
    logic [7:0]         c_duty;

    tpbc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage handshakes: each register moves when the one after it can take it.
    assign o_ready       = !m_valid_reg || m_axis_tready;
    assign c_ready       = !c_valid_reg || o_ready;
    assign b_ready       = !b_valid_reg || c_ready;
    assign a_go          = a_valid_reg && (!a_emit || b_ready);
    assign s_axis_tready = !a_valid_reg || a_go;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            a_action_reg <= s_axis_tuser[0];
            a_svalid_reg <= s_axis_tuser[1];
            a_age_reg    <= s_axis_tdata[15:0];
            a_tag_reg    <= s_axis_tdata[47:16];
            a_pitch_reg  <= $signed(s_axis_tdata[64:48]);
            a_rate_reg   <= $signed(s_axis_tdata[80:65]);
        end
    end

    // Sample filtering and tilt check.
    always_comb begin
        a_stop       = a_action_reg || !a_svalid_reg || (a_age_reg > cfg.stale_limit_ms);
        a_dup        = (a_tag_reg == prev_tag_reg);
        a_decim_next = decim_count_reg + 4'd1;
        a_skip       = (a_decim_next < DIVIDER);
        a_pitch_abs  = a_pitch_reg[16] ? 17'(-a_pitch_reg) : 17'(a_pitch_reg);
        a_trip       = (a_pitch_abs > {1'b0, cfg.trip_angle});
        a_halt       = a_stop || (!a_dup && !a_skip && a_trip);
        a_compute    = !a_stop && !a_dup && !a_skip && !a_trip;
        a_emit       = a_halt || a_compute;
        a_safe_next  = (!a_stop && !a_dup && !a_skip) ? !a_trip : safe_state_reg;
    end

    // State update as an item leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tag_reg    <= 32'd0;
            decim_count_reg <= '0;
            safe_state_reg  <= 1'b1;
        end else if (a_go && !a_stop && !a_dup) begin
            prev_tag_reg    <= a_tag_reg;
            decim_count_reg <= a_skip ? a_decim_next : '0;
            safe_state_reg  <= a_safe_next;
        end
    end

    // Proportional and derivative products.
    always_comb begin
        kp           = cfg.prop_gain;
        kd           = cfg.deriv_gain;
        a_err        = 18'(cfg.target_angle) - 18'(a_pitch_reg);
        a_prop_prod  = kp * a_err;
        a_deriv_prod = kd * a_rate_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_go && a_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready) begin
            b_halt_reg  <= a_halt;
            b_safe_reg  <= a_safe_next;
            b_prop_reg  <= a_prop_prod;
            b_deriv_reg <= a_deriv_prod;
        end
    end

    // Sum, magnitude and rounding; the low 16 fraction bits are dropped here.
    always_comb begin
        b_num     = (49'(b_deriv_reg) <<< 8) - 49'(b_prop_reg);
        b_mag     = b_num[48] ? 49'(-b_num) : 49'(b_num);
        b_rounded = b_mag + ROUND_BIAS;
        b_quot_in = b_rounded[48:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready) begin
            c_halt_reg    <= b_halt_reg;
            c_safe_reg    <= b_safe_reg;
            c_neg_reg     <= b_num[48];
            c_sat_reg     <= (b_quot_in >= SAT_LEVEL);
            c_quot_in_reg <= b_quot_in[13:0];
        end
    end

    // Divide by 100 through the reciprocal, clamp and restore the sign; a halt forces a zero duty.
    always_comb begin
        c_recip_prod = 27'(c_quot_in_reg) * RECIP_100;
        c_quot       = c_recip_prod[26:19];
        c_limit      = {1'b0, cfg.duty_limit};
        c_mag        = (c_sat_reg || (c_quot > c_limit)) ? c_limit : c_quot;
        if (c_halt_reg) begin
            c_duty = 8'd0;
        end else begin
            c_duty = c_neg_reg ? 8'(-c_mag) : c_mag;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_ready) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready) begin
            m_halt_reg <= c_halt_reg;
            m_safe_reg <= c_safe_reg;
            m_duty_reg <= c_duty;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_halt_reg;
    assign m_axis_tdata  = {7'd0, m_safe_reg, m_duty_reg};

    // A halt result never carries a duty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_halt_reg |-> m_duty_reg == 8'd0)
        else $error("halt item with nonzero duty");

    // A driving result stays within the duty clamp.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_halt_reg |->
            ($signed(m_duty_reg) <= $signed({1'b0, cfg.duty_limit}))
            && ($signed(m_duty_reg) >= -$signed({1'b0, cfg.duty_limit})))
        else $error("duty outside clamp");

    // A driving result is only produced in the safe state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_halt_reg |-> m_safe_reg)
        else $error("driving item flagged unsafe");

    // The decimation counter never reaches the divider.
    assert property (@(posedge aclk) disable iff (!aresetn)
        decim_count_reg < DIVIDER)
        else $error("decimation counter out of range");

    // A trip leaves the controller in the unsafe state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_go && !a_stop && !a_dup && !a_skip && a_trip |=> !safe_state_reg)
        else $error("tilt trip did not clear safe state");

endmodule

### hw/rtl/tpbc_regs.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module tpbc_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpbc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tpbc_pkg::cfg_t             cfg
);
    import tpbc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes; an address beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_TARGET: begin
                    cfg_reg.target_angle <= $signed(pwdata[16:0]);
                end
                REG_PROP: begin
                    cfg_reg.prop_gain <= $signed(pwdata[23:0]);
                end
                REG_DERIV: begin
                    cfg_reg.deriv_gain <= $signed(pwdata[23:0]);
                end
                REG_TRIP: begin
                    cfg_reg.trip_angle <= pwdata[15:0];
                end
                REG_STALE: begin
                    cfg_reg.stale_limit_ms <= pwdata[15:0];
                end
                REG_LIMIT: begin
                    cfg_reg.duty_limit <= pwdata[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back of the stored register bits.
    always_comb begin
        case (reg_sel)
            REG_TARGET: prdata = {15'd0, cfg_reg.target_angle};
            REG_PROP:   prdata = {8'd0, cfg_reg.prop_gain};
            REG_DERIV:  prdata = {8'd0, cfg_reg.deriv_gain};
            REG_TRIP:   prdata = {16'd0, cfg_reg.trip_angle};
            REG_STALE:  prdata = {16'd0, cfg_reg.stale_limit_ms};
            REG_LIMIT:  prdata = {25'd0, cfg_reg.duty_limit};
            default:    prdata = 32'd0;
        endcase
    end

endmodule
